// ----- rtl/lrd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lrd_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;

   // Input item kinds carried in req_tuser.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SETUP = 5'b00010,
      S_MUL   = 5'b00100,
      S_DIV   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/line_rasterizer_with_depth.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Line rasterizer with depth. On a load transfer (req_tuser = 0), the transfer
// cycle orders the endpoints by row, S_SETUP sets up the Bresenham terms, and
// S_MUL forms the depth numerator base * span with a single multiplier. A step
// transfer (req_tuser = 1) passes through the transfer cycle, then S_DIV with
// one restoring-divider iteration per depth bit (2 + DEPTH_FRAC_BITS), then
// S_OUT, which waits for the output register to be free, writes the fragment to
// it and advances the line. The restoring divider produces one quotient bit per
// cycle. req_tready is low while an item is in progress, and the output register
// lets the next item start while a fragment still waits on rsp. A step when no
// segment is active produces no fragment; a load with equal endpoints leaves no
// segment active.
module line_rasterizer_with_depth #(
   parameter int COORD_BITS      = 12,
   parameter int DEPTH_FRAC_BITS = 14,
   localparam int DEPTH_BITS     = DEPTH_FRAC_BITS + 2,
   localparam int REQ_BITS       = 4 * COORD_BITS + 2 * DEPTH_BITS,
   localparam int REQ_DATA_W     = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS       = 2 * COORD_BITS + DEPTH_BITS,
   localparam int RSP_DATA_W     = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // start_x, start_y, end_x, end_y, start_depth, end_depth, zero fill
   input  wire logic [REQ_DATA_W-1:0]              req_tdata,
   // func
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // pixel_x, pixel_y, depth, zero fill
   output logic [RSP_DATA_W-1:0]                   rsp_tdata,
   // on_screen
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lrd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [COORD_BITS-1:0]              csr_data
);
   import lrd_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int D      = DEPTH_BITS;
   localparam int ERR_W  = C + 3;
   localparam int NUM_W  = D + C + 1;
   localparam int CNT_W  = $clog2(D);
   localparam logic [C-1:0] SCREEN_RESET = C'(1024);

   state_type state_ff, state_in;

   logic [C-1:0]         width_ff, width_in;
   logic [C-1:0]         height_ff, height_in;

   logic signed [C-1:0]  col_ff, col_in;
   logic signed [C-1:0]  row_ff, row_in;
   logic signed [C:0]    dx_ff, dx_in;
   logic signed [C:0]    dy_ff, dy_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [C-1:0]         step_ff, step_in;
   logic [C-1:0]         major_ff, major_in;
   logic [C-1:0]         minor_ff, minor_in;
   logic                 x_major_ff, x_major_in;
   logic                 col_neg_ff, col_neg_in;
   logic                 row_neg_ff, row_neg_in;
   logic signed [D-1:0]  depth_base_ff, depth_base_in;
   logic signed [D:0]    depth_delta_ff, depth_delta_in;
   logic                 busy_ff, busy_in;

   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [C-1:0]         rem_ff, rem_in;
   logic [D-1:0]         quo_ff, quo_in;
   logic                 div_neg_ff, div_neg_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]         rsp_x_ff, rsp_x_in;
   logic [C-1:0]         rsp_y_ff, rsp_y_in;
   logic [D-1:0]         rsp_z_ff, rsp_z_in;
   logic                 rsp_on_ff, rsp_on_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Input fields.
   logic signed [C-1:0]  a_x, a_y, b_x, b_y;
   logic signed [D-1:0]  a_z, b_z;
   logic                 req_fire;
   logic                 a_first;

   // Setup terms.
   logic [C:0]           adx, ady;
   logic                 x_major_w;
   logic [C-1:0]         major_w, minor_w;

   // Divider step.
   logic [NUM_W-1:0]     num_mag;
   logic [C:0]           div_trial;
   logic [C:0]           div_diff;
   logic                 div_ge;

   // Fragment output and line advance.
   logic                 out_free;
   logic                 on_w, fin_w, step_minor;
   logic                 col_inc, row_inc;

   assign a_x = req_tdata[0*C +: C];
   assign a_y = req_tdata[1*C +: C];
   assign b_x = req_tdata[2*C +: C];
   assign b_y = req_tdata[3*C +: C];
   assign a_z = req_tdata[4*C +: D];
   assign b_z = req_tdata[4*C+D +: D];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign a_first    = a_y < b_y;

   assign csr_ready  = 1'b1;

   assign adx       = dx_ff[C] ? -dx_ff : dx_ff;
   assign ady       = dy_ff[C] ? -dy_ff : dy_ff;
   assign x_major_w = ady < adx;
   assign major_w   = x_major_w ? adx[C-1:0] : ady[C-1:0];
   assign minor_w   = x_major_w ? ady[C-1:0] : adx[C-1:0];

   assign num_mag   = num_ff[NUM_W-1] ? -num_ff : num_ff;
   assign div_trial = {rem_ff, quo_ff[D-1]};
   assign div_diff  = div_trial - {1'b0, major_ff};
   assign div_ge    = div_trial >= {1'b0, major_ff};

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign on_w       = !col_ff[C-1] && !row_ff[C-1] &&
                       (col_ff < width_ff) && (row_ff < height_ff);
   assign fin_w      = step_ff == (major_ff - C'(1));
   assign step_minor = !err_ff[ERR_W-1] && (err_ff != '0);
   assign col_inc    = x_major_ff || step_minor;
   assign row_inc    = !x_major_ff || step_minor;

   always_comb begin
      state_in       = state_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      err_in         = err_ff;
      step_in        = step_ff;
      major_in       = major_ff;
      minor_in       = minor_ff;
      x_major_in     = x_major_ff;
      col_neg_in     = col_neg_ff;
      row_neg_in     = row_neg_ff;
      depth_base_in  = depth_base_ff;
      depth_delta_in = depth_delta_ff;
      busy_in        = busy_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      div_neg_in     = div_neg_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_z_in       = rsp_z_ff;
      rsp_on_in      = rsp_on_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_data;
            CSR_SCREEN_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == FUNC_LOAD) begin
                  // Start from the endpoint with the lower row; a tie starts at the second.
                  col_in         = a_first ? a_x : b_x;
                  row_in         = a_first ? a_y : b_y;
                  dx_in          = a_first ? ((C+1)'(b_x) - (C+1)'(a_x))
                                           : ((C+1)'(a_x) - (C+1)'(b_x));
                  dy_in          = a_first ? ((C+1)'(b_y) - (C+1)'(a_y))
                                           : ((C+1)'(a_y) - (C+1)'(b_y));
                  depth_base_in  = a_first ? a_z : b_z;
                  depth_delta_in = a_first ? ((D+1)'(b_z) - (D+1)'(a_z))
                                           : ((D+1)'(a_z) - (D+1)'(b_z));
                  step_in        = '0;
                  busy_in        = 1'b0;
                  state_in       = S_SETUP;
               end else if (busy_ff) begin
                  // The divider needs num / span < 2^D, which holds because the
                  // interpolated depth lies between the endpoint depths.
                  rem_in     = num_mag[D +: C];
                  quo_in     = num_mag[D-1:0];
                  div_neg_in = num_ff[NUM_W-1];
                  cnt_in     = CNT_W'(D - 1);
                  state_in   = S_DIV;
               end
            end
         end
         S_SETUP: begin
            col_neg_in = dx_ff[C];
            row_neg_in = dy_ff[C];
            x_major_in = x_major_w;
            major_in   = major_w;
            minor_in   = minor_w;
            err_in     = $signed(ERR_W'({minor_w, 1'b0}) - ERR_W'(major_w));
            state_in   = S_MUL;
         end
         S_MUL: begin
            num_in   = NUM_W'(depth_base_ff) * NUM_W'($signed({1'b0, major_ff}));
            busy_in  = major_ff != '0;
            state_in = S_IDLE;
         end
         S_DIV: begin
            rem_in = div_ge ? div_diff[C-1:0] : div_trial[C-1:0];
            quo_in = {quo_ff[D-2:0], div_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = col_ff;
               rsp_y_in     = row_ff;
               rsp_z_in     = div_neg_ff ? -quo_ff : quo_ff;
               rsp_on_in    = on_w;
               rsp_last_in  = fin_w;

               if (col_inc) begin
                  col_in = col_neg_ff ? col_ff - C'(1) : col_ff + C'(1);
               end
               if (row_inc) begin
                  row_in = row_neg_ff ? row_ff - C'(1) : row_ff + C'(1);
               end
               err_in  = err_ff + $signed(ERR_W'({minor_ff, 1'b0}))
                         - (step_minor ? $signed(ERR_W'({major_ff, 1'b0})) : $signed(ERR_W'(0)));
               num_in  = num_ff + NUM_W'(depth_delta_ff);
               step_in = step_ff + C'(1);
               if (fin_w) begin
                  busy_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         width_ff       <= SCREEN_RESET;
         height_ff      <= SCREEN_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
         err_ff         <= '0;
         step_ff        <= '0;
         major_ff       <= '0;
         minor_ff       <= '0;
         x_major_ff     <= 1'b0;
         col_neg_ff     <= 1'b0;
         row_neg_ff     <= 1'b0;
         depth_base_ff  <= '0;
         depth_delta_ff <= '0;
         busy_ff        <= 1'b0;
         num_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         err_ff         <= err_in;
         step_ff        <= step_in;
         major_ff       <= major_in;
         minor_ff       <= minor_in;
         x_major_ff     <= x_major_in;
         col_neg_ff     <= col_neg_in;
         row_neg_ff     <= row_neg_in;
         depth_base_ff  <= depth_base_in;
         depth_delta_ff <= depth_delta_in;
         busy_ff        <= busy_in;
         num_ff         <= num_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_neg_ff  <= div_neg_in;
      cnt_ff      <= cnt_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_on_ff   <= rsp_on_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_z_ff, rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_on_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/lrd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lrd_checker #(
   parameter int COORD_BITS      = 12,
   parameter int DEPTH_FRAC_BITS = 14,
   localparam int DEPTH_BITS     = DEPTH_FRAC_BITS + 2,
   localparam int RSP_BITS       = 2 * COORD_BITS + DEPTH_BITS,
   localparam int RSP_DATA_W     = ((RSP_BITS + 7) / 8) * 8
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               req_tuser,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [RSP_DATA_W-1:0]              rsp_tdata,
   input wire logic                               rsp_tuser,
   input wire logic                               rsp_tlast
);
   import lrd_pkg::*;

   // The block comes out of reset idle with nothing to send.
   assert property (@(posedge clock) $past(reset) |-> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // A held fragment keeps its payload until the transfer completes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled fragment changed");

   // A segment load always spends cycles in setup before the next item.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == FUNC_LOAD) |=> !req_tready)
      else $error("load did not enter setup");

   // A new fragment is written only from the output step, when input is closed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("fragment appeared without a step in progress");

   // An on-screen fragment never has a negative coordinate.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[COORD_BITS-1] && !rsp_tdata[2*COORD_BITS-1])
      else $error("on-screen fragment with negative coordinate");

endmodule

bind line_rasterizer_with_depth lrd_checker #(
   .COORD_BITS      (COORD_BITS),
   .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
) u_lrd_checker (.*);

`default_nettype wire
